>>> src/dvwx_pkg.sv
// Package for the Devanagari UTF-8 to WX transliteration unit.
// Holds byte and index constants, the WX letter ROM and the queue entry types.
// No dependencies.
`default_nettype none

package dvwx_pkg;

  localparam logic [7:0] PAGE_LOW   = 8'hA4;
  localparam logic [7:0] PAGE_HIGH  = 8'hA5;
  localparam logic [7:0] LEAD_DEV   = 8'hE0;
  localparam logic [7:0] CONT_BASE  = 8'h80;

  localparam logic [6:0] IDX_CONS_LO  = 7'd21;
  localparam logic [6:0] IDX_CONS_HI  = 7'd57;
  localparam logic [6:0] IDX_NUKTA    = 7'd60;
  localparam logic [6:0] IDX_VOWEL_LO = 7'd62;
  localparam logic [6:0] IDX_VOWEL_HI = 7'd76;
  localparam logic [6:0] IDX_HALANT   = 7'd77;
  localparam logic [6:0] IDX_A5_LO    = 7'd96;
  localparam logic [6:0] IDX_A5_HI    = 7'd111;
  localparam logic [6:0] ROM_SIZE     = 7'd112;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_NUKTA = 8'h5A;

  localparam int MAX_OUT = 4;

  localparam logic [7:0] WX_ROM [112] = '{
    8'h20, 8'h7A, 8'h4D, 8'h48, 8'h20, 8'h61, 8'h41, 8'h69,
    8'h49, 8'h75, 8'h55, 8'h71, 8'h4C, 8'h20, 8'h20, 8'h65,
    8'h45, 8'h20, 8'h20, 8'h6F, 8'h4F, 8'h6B, 8'h4B, 8'h67,
    8'h47, 8'h66, 8'h63, 8'h43, 8'h6A, 8'h4A, 8'h46, 8'h74,
    8'h54, 8'h64, 8'h44, 8'h4E, 8'h77, 8'h57, 8'h78, 8'h58,
    8'h6E, 8'h6E, 8'h70, 8'h50, 8'h62, 8'h42, 8'h6D, 8'h79,
    8'h72, 8'h72, 8'h6C, 8'h20, 8'h20, 8'h76, 8'h53, 8'h52,
    8'h73, 8'h68, 8'h20, 8'h20, 8'h5A, 8'h20, 8'h41, 8'h69,
    8'h49, 8'h75, 8'h55, 8'h71, 8'h51, 8'h20, 8'h20, 8'h65,
    8'h45, 8'h20, 8'h20, 8'h6F, 8'h4F, 8'h20, 8'h20, 8'h60,
    8'h27, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
    8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
    8'h51, 8'h20, 8'h20, 8'h20, 8'h2E, 8'h2E, 8'h30, 8'h31,
    8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39
  };

  function automatic logic [7:0] wx_letter(input logic [6:0] idx);
    logic [7:0] c;
    c = CH_SPACE;
    if (idx < ROM_SIZE) begin
      c = WX_ROM[idx];
    end
    return c;
  endfunction

  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] chars;
    logic [1:0]              last;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

`default_nettype wire

>>> src/dvwx_in_if.sv
// Input byte channel: valid/ready handshake carrying one UTF-8 byte.
// No dependencies.
`default_nettype none

interface dvwx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

>>> src/dvwx_out_if.sv
// Output character channel: valid/ready handshake carrying one result byte.
// No dependencies.
`default_nettype none

interface dvwx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

`default_nettype wire

>>> src/devanagari_utf8_to_wx_translit_unit.sv
// Devanagari UTF-8 to WX transliteration unit, top level.
// Front end is combinational; the queue and the back-end output stage are registered.
// Throughput: one byte per cycle while the queue is not full.
// The entry queue of QUEUE_DEPTH entries decouples input from output stalls.
// Reset: synchronous on rst; clears group and vowel state and empties the queue.
// Depends on dvwx_pkg, dvwx_in_if, dvwx_out_if, dvwx_front, dvwx_queue, dvwx_back.
`default_nettype none

module devanagari_utf8_to_wx_translit_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  dvwx_in_if.sink     in_item,
  dvwx_out_if.source  out_item
);

  dvwx_pkg::push_t push;
  dvwx_pkg::head_t head;
  logic            full;
  logic            pop;

  assign in_item.ready = !full;

  dvwx_front u_front (
    .clk     (clk),
    .rst     (rst),
    .valid   (in_item.valid),
    .in_byte (in_item.in_byte),
    .accept  (!full),
    .push    (push)
  );

  dvwx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .head (head),
    .pop  (pop)
  );

  dvwx_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .valid    (out_item.valid),
    .out_char (out_item.out_char),
    .run_last (out_item.run_last),
    .ready    (out_item.ready)
  );

endmodule

`default_nettype wire

>>> src/dvwx_front.sv
// Front end: tracks group position and pending vowel, classifies each byte
// into a queue entry of up to four result characters. Uses dvwx_pkg.
`default_nettype none

module dvwx_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          valid,
  input  wire logic [7:0]    in_byte,
  input  wire logic          accept,
  output dvwx_pkg::push_t    push
);

  logic [1:0] group_position, group_position_next;
  logic [7:0] lead_byte, lead_byte_next;
  logic [7:0] middle_byte, middle_byte_next;
  logic       vowel_pending, vowel_pending_next;
  logic       after_nukta, after_nukta_next;

  logic                              dev;
  logic [6:0]                        idx;
  logic                              do_fresh;
  logic [2:0]                        cnt;
  logic [dvwx_pkg::MAX_OUT-1:0][7:0] chars;

  assign dev = (lead_byte == dvwx_pkg::LEAD_DEV) &&
               ((middle_byte == dvwx_pkg::PAGE_LOW) || (middle_byte == dvwx_pkg::PAGE_HIGH)) &&
               (in_byte[7:6] == dvwx_pkg::CONT_BASE[7:6]);
  assign idx = {middle_byte == dvwx_pkg::PAGE_HIGH, in_byte[5:0]};

  always_comb begin
    group_position_next = group_position;
    lead_byte_next      = lead_byte;
    middle_byte_next    = middle_byte;
    vowel_pending_next  = vowel_pending;
    after_nukta_next    = after_nukta;
    do_fresh            = 1'b0;
    cnt                 = 3'd0;
    chars               = '0;

    unique case (group_position)
      2'd1: begin
        middle_byte_next    = in_byte;
        group_position_next = 2'd2;
      end
      2'd2: begin
        group_position_next = 2'd0;
        if (vowel_pending) begin
          if (dev && idx >= dvwx_pkg::IDX_VOWEL_LO && idx <= dvwx_pkg::IDX_VOWEL_HI) begin
            chars[cnt[1:0]]    = dvwx_pkg::wx_letter(idx);
            cnt                = cnt + 3'd1;
            vowel_pending_next = 1'b0;
            after_nukta_next   = 1'b0;
          end else if (dev && idx == dvwx_pkg::IDX_HALANT) begin
            vowel_pending_next = 1'b0;
            after_nukta_next   = 1'b0;
          end else if (dev && idx == dvwx_pkg::IDX_NUKTA && !after_nukta) begin
            chars[cnt[1:0]]  = dvwx_pkg::CH_NUKTA;
            cnt              = cnt + 3'd1;
            after_nukta_next = 1'b1;
          end else begin
            chars[cnt[1:0]]    = dvwx_pkg::CH_A;
            cnt                = cnt + 3'd1;
            vowel_pending_next = 1'b0;
            after_nukta_next   = 1'b0;
            do_fresh           = 1'b1;
          end
        end else begin
          do_fresh = 1'b1;
        end
      end
      default: begin
        if (in_byte == 8'h00) begin
          // NUL: drop
        end else if (in_byte[7] == 1'b0) begin
          if (vowel_pending) begin
            chars[cnt[1:0]]    = dvwx_pkg::CH_A;
            cnt                = cnt + 3'd1;
            vowel_pending_next = 1'b0;
            after_nukta_next   = 1'b0;
          end
          chars[cnt[1:0]] = in_byte;
          cnt             = cnt + 3'd1;
        end else begin
          lead_byte_next      = in_byte;
          group_position_next = 2'd1;
        end
      end
    endcase

    if (do_fresh) begin
      if (!dev) begin
        chars[cnt[1:0]] = lead_byte;
        cnt             = cnt + 3'd1;
        chars[cnt[1:0]] = middle_byte;
        cnt             = cnt + 3'd1;
        chars[cnt[1:0]] = in_byte;
        cnt             = cnt + 3'd1;
      end else if (middle_byte == dvwx_pkg::PAGE_LOW) begin
        chars[cnt[1:0]] = dvwx_pkg::wx_letter(idx);
        cnt             = cnt + 3'd1;
        if (idx >= dvwx_pkg::IDX_CONS_LO && idx <= dvwx_pkg::IDX_CONS_HI) begin
          vowel_pending_next = 1'b1;
        end
      end else if (idx >= dvwx_pkg::IDX_A5_LO && idx <= dvwx_pkg::IDX_A5_HI) begin
        chars[cnt[1:0]] = dvwx_pkg::wx_letter(idx);
        cnt             = cnt + 3'd1;
      end
    end

    push.valid       = valid && accept && (cnt != 3'd0);
    push.entry.chars = chars;
    push.entry.last  = 2'(cnt - 3'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position <= 2'd0;
      lead_byte      <= 8'h00;
      middle_byte    <= 8'h00;
      vowel_pending  <= 1'b0;
      after_nukta    <= 1'b0;
    end else if (valid && accept) begin
      group_position <= group_position_next;
      lead_byte      <= lead_byte_next;
      middle_byte    <= middle_byte_next;
      vowel_pending  <= vowel_pending_next;
      after_nukta    <= after_nukta_next;
    end
  end

endmodule

`default_nettype wire

>>> src/dvwx_queue.sv
// Entry queue between front and back ends: a small circular buffer.
// Uses dvwx_pkg.
`default_nettype none

module dvwx_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  dvwx_pkg::push_t   push,
  output logic              full,
  output dvwx_pkg::head_t   head,
  input  wire logic         pop
);

  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dvwx_pkg::entry_t store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = store[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/dvwx_back.sv
// Back end: steps through the characters of the head entry, one per cycle unless
// the output is stalled, into a registered output stage. Uses dvwx_pkg.
`default_nettype none

module dvwx_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  dvwx_pkg::head_t  head,
  output logic             pop,
  output logic             valid,
  output logic [7:0]       out_char,
  output logic             run_last,
  input  wire logic        ready
);

  logic [1:0] pos;
  logic       load;
  logic       at_last;

  assign load    = !valid || ready;
  assign at_last = (pos == head.entry.last);
  assign pop     = load && head.valid && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      pos   <= 2'd0;
    end else if (load) begin
      valid <= head.valid;
      if (head.valid) begin
        pos <= at_last ? 2'd0 : pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head.valid) begin
      out_char <= head.entry.chars[pos];
      run_last <= at_last;
    end
  end

endmodule

`default_nettype wire

>>> src/dvwx_checker.sv
// Port-level checks for the transliteration unit, bound to its top level.
// Depends on devanagari_utf8_to_wx_translit_unit.
`default_nettype none

module dvwx_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char,
  input wire logic       run_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_char) && $stable(run_last))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown straight after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready straight after reset");

endmodule

bind devanagari_utf8_to_wx_translit_unit dvwx_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_item.ready),
  .out_valid (out_item.valid),
  .out_ready (out_item.ready),
  .out_char  (out_item.out_char),
  .run_last  (out_item.run_last)
);

`default_nettype wire

>>> test/devanagari_utf8_to_wx_translit_unit_tb.sv
// Testbench for the Devanagari UTF-8 to WX transliteration unit.
// Feeds a directed table and random syllable-shaped byte streams, predicts each transfer.
// Depends on dvwx_in_if, dvwx_out_if and devanagari_utf8_to_wx_translit_unit.

module devanagari_utf8_to_wx_translit_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] LEAD_DEV    = 8'hE0;
  localparam logic [7:0] PAGE_LO     = 8'hA4;
  localparam logic [7:0] PAGE_HI     = 8'hA5;
  localparam logic [7:0] CONT_BASE   = 8'h80;
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_INHERENT = 8'h61;
  localparam logic [7:0] CH_NUKTA    = 8'h5A;

  localparam logic [6:0] IX_CONS_LO  = 7'd21;
  localparam logic [6:0] IX_CONS_HI  = 7'd57;
  localparam logic [6:0] IX_NUKTA    = 7'd60;
  localparam logic [6:0] IX_VOWEL_LO = 7'd62;
  localparam logic [6:0] IX_VOWEL_HI = 7'd76;
  localparam logic [6:0] IX_HALANT   = 7'd77;
  localparam logic [6:0] IX_A5_LO    = 7'd96;
  localparam logic [6:0] IX_A5_HI    = 7'd111;
  localparam logic [6:0] ROM_LEN     = 7'd112;

  localparam logic [0:111][7:0] WX_LETTERS = {
    " zMH aAiIuUqL  e", "E  oOkKgGfcCjJFt", "TdDNwWxXnnpPbBmy", "rrl  vSRsh  Z Ai",
    "IuUqQ  eE  oO  ", 8'h60, 8'h27, {15{8'h20}}, "Q   ..0123456789"
  };

  localparam int RANDOM_BYTES = 100;
  localparam int LONG_HOLD    = 80;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } wx_char_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    logic       gives;
    logic [7:0] ch;
  } table_row_t;

  localparam int N_ROWS = 31;
  localparam table_row_t STIMULUS_TABLE [N_ROWS] = '{
    '{8'h00, 1'b1, 1'b0, 8'h00}, '{8'h7F, 1'b1, 1'b1, 8'h7F},
    '{8'hE0, 1'b1, 1'b0, 8'h00}, '{8'hA4, 1'b1, 1'b0, 8'h00}, '{8'h95, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b1, 1'b0, 8'h00},
    '{8'hE0, 1'b1, 1'b0, 8'h00}, '{8'hA4, 1'b1, 1'b0, 8'h00}, '{8'hBC, 1'b0, 1'b0, 8'h00},
    '{8'hE0, 1'b0, 1'b0, 8'h00}, '{8'hA5, 1'b0, 1'b0, 8'h00}, '{8'h80, 1'b0, 1'b0, 8'h00},
    '{8'hE0, 1'b0, 1'b0, 8'h00}, '{8'hA4, 1'b0, 1'b0, 8'h00}, '{8'hB8, 1'b0, 1'b0, 8'h00},
    '{8'hFF, 1'b1, 1'b0, 8'h00}, '{8'h00, 1'b1, 1'b0, 8'h00}, '{8'h41, 1'b0, 1'b0, 8'h00},
    '{8'hE0, 1'b0, 1'b0, 8'h00}, '{8'hA5, 1'b0, 1'b0, 8'h00}, '{8'hBF, 1'b0, 1'b0, 8'h00},
    '{8'hE0, 1'b0, 1'b0, 8'h00}, '{8'hA5, 1'b0, 1'b0, 8'h00}, '{8'hA6, 1'b0, 1'b0, 8'h00},
    '{8'hE0, 1'b0, 1'b0, 8'h00}, '{8'hA4, 1'b0, 1'b0, 8'h00}, '{8'h95, 1'b0, 1'b0, 8'h00},
    '{8'hE0, 1'b0, 1'b0, 8'h00}, '{8'hA5, 1'b0, 1'b0, 8'h00}, '{8'h8D, 1'b0, 1'b0, 8'h00},
    '{8'h01, 1'b1, 1'b1, 8'h01}
  };

  logic clk;
  logic rst;

  dvwx_in_if  byte_ch ();
  dvwx_out_if char_ch ();

  devanagari_utf8_to_wx_translit_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_item  (byte_ch),
    .out_item (char_ch)
  );

  logic [1:0] grp_pos    = 2'd0;
  logic [7:0] lead_b     = 8'h00;
  logic [7:0] mid_b      = 8'h00;
  logic       pending    = 1'b0;
  logic       nukta_done = 1'b0;

  wx_char_t step_chars[$];
  wx_char_t expected_chars[$];

  int  mismatches   = 0;
  int  bytes_fed    = 0;
  int  feed_calm    = 0;
  int  take_calm    = 0;
  int  quiet_cycles = 0;
  bit  long_hold_due = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm_left = $urandom_range(5, 20);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [7:0] wx_of(input logic [6:0] idx);
    return (idx < ROM_LEN) ? WX_LETTERS[idx] : CH_SPACE;
  endfunction

  function automatic void emit(input logic [7:0] c);
    wx_char_t e;
    e.ch = c;
    e.last = 1'b0;
    step_chars.push_back(e);
  endfunction

  function automatic void clear_vowel();
    pending = 1'b0;
    nukta_done = 1'b0;
  endfunction

  function automatic void fresh_group(input logic dev, input logic [6:0] idx,
                                      input logic [7:0] third);
    if (!dev) begin
      emit(lead_b);
      emit(mid_b);
      emit(third);
    end else if (mid_b == PAGE_LO) begin
      emit(wx_of(idx));
      if (idx >= IX_CONS_LO && idx <= IX_CONS_HI) pending = 1'b1;
    end else if (idx >= IX_A5_LO && idx <= IX_A5_HI) begin
      emit(wx_of(idx));
    end
  endfunction

  function automatic void translit_step(input logic [7:0] b);
    logic       dev;
    logic [6:0] idx;
    step_chars.delete();
    if (grp_pos == 2'd1) begin
      mid_b = b;
      grp_pos = 2'd2;
    end else if (grp_pos == 2'd2) begin
      grp_pos = 2'd0;
      dev = lead_b == LEAD_DEV && (mid_b == PAGE_LO || mid_b == PAGE_HI) &&
            b[7:6] == CONT_BASE[7:6];
      idx = {mid_b == PAGE_HI, b[5:0]};
      if (pending) begin
        if (dev && idx >= IX_VOWEL_LO && idx <= IX_VOWEL_HI) begin
          emit(wx_of(idx));
          clear_vowel();
        end else if (dev && idx == IX_HALANT) begin
          clear_vowel();
        end else if (dev && idx == IX_NUKTA && !nukta_done) begin
          emit(CH_NUKTA);
          nukta_done = 1'b1;
        end else begin
          emit(CH_INHERENT);
          clear_vowel();
          fresh_group(dev, idx, b);
        end
      end else begin
        fresh_group(dev, idx, b);
      end
    end else if (b[7]) begin
      lead_b = b;
      grp_pos = 2'd1;
    end else if (b != CH_NUL) begin
      if (pending) begin
        emit(CH_INHERENT);
        clear_vowel();
      end
      emit(b);
    end
  endfunction

  task automatic feed_byte(input logic [7:0] b, input logic typed, input logic gives,
                           input logic [7:0] ch);
    int gap;
    gap = draw_wait(feed_calm);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.in_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    translit_step(b);
    if (typed) begin
      step_chars.delete();
      if (gives) emit(ch);
    end
    if (step_chars.size() != 0) step_chars[step_chars.size() - 1].last = 1'b1;
    while (step_chars.size() != 0) expected_chars.push_back(step_chars.pop_front());
    bytes_fed++;
  endtask

  task automatic feed_plain(input logic [7:0] b);
    feed_byte(b, 1'b0, 1'b0, CH_NUL);
  endtask

  task automatic feed_group(input logic [7:0] lead, input logic [7:0] mid,
                            input logic [7:0] third);
    feed_plain(lead);
    feed_plain(mid);
    feed_plain(third);
  endtask

  task automatic feed_letter(input logic [6:0] idx);
    feed_group(LEAD_DEV, idx[6] ? PAGE_HI : PAGE_LO, CONT_BASE | {2'b00, idx[5:0]});
  endtask

  task automatic feed_random_word();
    int         kind;
    logic [7:0] third;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      feed_letter(7'($urandom_range(IX_CONS_LO, IX_CONS_HI)));
      case ($urandom_range(0, 5))
        0: feed_letter(7'($urandom_range(IX_VOWEL_LO, IX_VOWEL_HI)));
        1: feed_letter(IX_HALANT);
        2: begin
          feed_letter(IX_NUKTA);
          if ($urandom_range(0, 1) == 1) feed_letter(IX_NUKTA);
          else feed_letter(7'($urandom_range(IX_VOWEL_LO, IX_VOWEL_HI)));
        end
        3: feed_plain(8'($urandom_range(1, 127)));
        default: ;
      endcase
    end else if (kind < 60) begin
      feed_plain(8'($urandom_range(1, 127)));
    end else if (kind < 65) begin
      feed_plain(CH_NUL);
    end else if (kind < 75) begin
      feed_letter(7'($urandom_range(0, 127)));
    end else if (kind < 80) begin
      feed_letter(7'($urandom_range(IX_A5_LO, IX_A5_HI)));
    end else if (kind < 88) begin
      feed_group(8'($urandom_range(128, 255)), 8'($urandom), 8'($urandom));
    end else if (kind < 94) begin
      third = 8'($urandom);
      if (third[7:6] == CONT_BASE[7:6]) third[6] = 1'b1;
      feed_group(LEAD_DEV, ($urandom_range(0, 1) == 1) ? PAGE_HI : PAGE_LO, third);
    end else begin
      feed_plain(8'($urandom));
    end
  endtask

  initial begin : byte_sender
    bit paused;
    paused = 1'b0;
    rst <= 1'b1;
    byte_ch.valid <= 1'b0;
    byte_ch.in_byte <= 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_ROWS; i++) begin
      feed_byte(STIMULUS_TABLE[i].b, STIMULUS_TABLE[i].typed, STIMULUS_TABLE[i].gives,
                STIMULUS_TABLE[i].ch);
    end
    long_hold_due = 1'b1;
    while (bytes_fed < N_ROWS + RANDOM_BYTES) begin
      if (!paused && bytes_fed >= N_ROWS + RANDOM_BYTES / 2) begin
        paused = 1'b1;
        byte_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_chars.size() != 0);
      end
      feed_random_word();
    end
    byte_ch.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("devanagari_utf8_to_wx_translit_unit regression: pass");
    end else begin
      $display("devanagari_utf8_to_wx_translit_unit regression: fail");
    end
    $finish;
  end

  initial begin : char_receiver
    int stall;
    char_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_due) begin
        stall = LONG_HOLD;
        long_hold_due = 1'b0;
      end else begin
        stall = draw_wait(take_calm);
      end
      if (stall > 0) begin
        char_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      char_ch.ready <= 1'b1;
      @(posedge clk);
      while (!char_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : char_checker
    wx_char_t want;
    if (!rst && char_ch.valid && char_ch.ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %h", char_ch.out_char));
      end else begin
        want = expected_chars.pop_front();
        if (char_ch.out_char !== want.ch) begin
          report_mismatch($sformatf("out_char %h, want %h", char_ch.out_char, want.ch));
        end
        if (char_ch.run_last !== want.last) begin
          report_mismatch($sformatf("run_last %b, want %b", char_ch.run_last, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (byte_ch.valid && byte_ch.ready) || (char_ch.valid && char_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("devanagari_utf8_to_wx_translit_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> files.f
src/dvwx_pkg.sv
src/dvwx_in_if.sv
src/dvwx_out_if.sv
src/dvwx_front.sv
src/dvwx_queue.sv
src/dvwx_back.sv
src/devanagari_utf8_to_wx_translit_unit.sv
src/dvwx_checker.sv
test/devanagari_utf8_to_wx_translit_unit_tb.sv
